FILE: sv/flash_page_command_address_gen_assert.svh
// Assertion macros for the checker file.
`ifndef FLASH_PAGE_COMMAND_ADDRESS_GEN_ASSERT_SVH
`define FLASH_PAGE_COMMAND_ADDRESS_GEN_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define FPCAG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle property failed");

// Next-cycle implication, disabled in reset.
`define FPCAG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle property failed");

`endif

FILE: sv/fpcag_pkg.sv
`default_nettype none

package fpcag_pkg;

   // field widths
   localparam int ADDR_W     = 24;
   localparam int LEN_W      = 14;
   localparam int ACT_W      = 2;
   localparam int OP_W       = 8;
   localparam int PSIZE_W    = 10;
   localparam int PAGE_W     = 16;
   localparam int SHIFT_W    = 4;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;
   localparam int DENS_W     = 4;

   localparam int MAX_LENGTH_DEF = 8192;

   // restoring divider: one quotient bit per cycle
   localparam int DIV_STEPS = ADDR_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // request actions
   typedef enum logic [ACT_W-1:0] {
      ACT_READ    = 2'd0,
      ACT_PROGRAM = 2'd1,
      ACT_ERASE   = 2'd2,
      ACT_BAD     = 2'd3
   } action_type;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEVICE_READY = 2'd0,
      CSR_DENSITY_CODE = 2'd1,
      CSR_BINARY_PAGES = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   // command opcodes
   localparam logic [OP_W-1:0] OP_NONE    = 8'h00;
   localparam logic [OP_W-1:0] OP_READ    = 8'h03;
   localparam logic [OP_W-1:0] OP_PROGRAM = 8'h02;
   localparam logic [OP_W-1:0] OP_ERASE   = 8'h81;

   // page geometry
   localparam logic [PSIZE_W-1:0] PSIZE_BIN_SMALL = 10'h100;
   localparam logic [PSIZE_W-1:0] PSIZE_BIN_BIG   = 10'h200;
   localparam logic [PSIZE_W-1:0] PSIZE_EXT_SMALL = 10'h108;
   localparam logic [PSIZE_W-1:0] PSIZE_EXT_BIG   = 10'h210;
   localparam logic [SHIFT_W-1:0] SHIFT_BIN_SMALL = 4'd8;
   localparam logic [SHIFT_W-1:0] SHIFT_BIN_BIG   = 4'd9;
   localparam logic [SHIFT_W-1:0] SHIFT_EXT_SMALL = 4'd9;
   localparam logic [SHIFT_W-1:0] SHIFT_EXT_BIG   = 4'd10;

   // density codes; device bytes are 0x8000 << code
   localparam logic [DENS_W-1:0] DENS_MIN    = 4'd3;
   localparam logic [DENS_W-1:0] DENS_MAX    = 4'd8;
   localparam logic [DENS_W-1:0] DENS_BIG_LO = 4'd6;
   localparam logic [DENS_W-1:0] DENS_BIG_HI = 4'd7;
   localparam logic [DENS_W-1:0] DENS_RESET  = 4'd3;
   localparam int DEV_BASE_LOG2 = 15;
   // extended pages scale device size by 33/32
   localparam int EXT_SCALE_SHIFT = 5;

   typedef struct packed {
      logic               start;
      logic [ADDR_W-1:0]  dividend;
      logic [PSIZE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [ADDR_W-1:0]  quot;
      logic [PSIZE_W-1:0] rem;
   } div_res_type;

endpackage

`default_nettype wire

FILE: sv/fpcag_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. done pulses for one cycle
// with the final quotient and remainder.
module fpcag_div
   import fpcag_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  div_req_type div_req,
   output div_res_type div_res
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0]    dvd_ff, dvd_in;
   logic [PSIZE_W-1:0]   rem_ff, rem_in;
   logic [PSIZE_W-1:0]   dvs_ff, dvs_in;

   logic [PSIZE_W:0] trial;
   logic [PSIZE_W:0] diff;
   logic             ge;

   // one compare/subtract step
   always_comb begin
      trial = {rem_ff, dvd_ff[ADDR_W-1]};
      ge    = trial >= {1'b0, dvs_ff};
      diff  = trial - {1'b0, dvs_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[PSIZE_W-1:0] : trial[PSIZE_W-1:0];
         dvd_in = {dvd_ff[ADDR_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_res.done = done_ff;
   assign div_res.quot = dvd_ff;
   assign div_res.rem  = rem_ff;

endmodule

`default_nettype wire

FILE: sv/flash_page_command_address_gen.sv
`default_nettype none

// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tdata: action, address, length
// rsp      out  rsp_tvalid/rsp_tready  tdata: opcode, device_address, byte_count
//                                      tuser: status, tlast: last
// csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// One request at a time; req_tready is high only when idle.
// Order: a check, the address divide (plus a length divide for erase), then
// a step and a send per result, the send held by any rsp stall. Rejects at the
// check go straight to send; misaligned erases are refused after a 24-step divide.
// Reset (synchronous) restores the configuration registers to their defaults and idles.
// csr writes are taken whenever out of reset; csr_ready is tied high.
module flash_page_command_address_gen
   import fpcag_pkg::*;
#(
   parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF
)
(
   input  wire                    clock,
   input  wire                    reset,
   // action[1:0], address[25:2], length[39:26]
   input  wire [REQ_DATA_W-1:0]   req_tdata,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   // opcode[7:0], device_address[31:8], byte_count[45:32], zeros above
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // status
   output logic                   rsp_tuser,
   output logic                   rsp_tlast,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire [CSR_IDX_W-1:0]    csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIV_ADDR,
      S_DIV_LEN,
      S_STEP,
      S_SEND
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic              ready_cfg_ff;
   logic [DENS_W-1:0] density_ff;
   logic              binary_ff;

   // request and walk
   action_type         action_ff, action_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   remain_ff, remain_in;
   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [PSIZE_W-1:0] off_ff, off_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OP_W-1:0]    out_op_ff, out_op_in;
   logic [ADDR_W-1:0]  out_dev_ff, out_dev_in;
   logic [LEN_W-1:0]   out_cnt_ff, out_cnt_in;
   logic               out_status_ff, out_status_in;
   logic               out_last_ff, out_last_in;

   div_req_type div_req;
   div_res_type div_res;

   // geometry from configuration
   logic               big;
   logic [PSIZE_W-1:0] psize;
   logic [SHIFT_W-1:0] page_shift;
   logic [ADDR_W:0]    dsize_bin;
   logic [ADDR_W:0]    dsize;
   logic [ADDR_W:0]    req_end;
   logic               bad_req;

   // per-result values
   logic [PSIZE_W-1:0] room;
   logic               seg_last;
   logic [LEN_W-1:0]   seg;
   logic [ADDR_W-1:0]  dev_addr;

   fpcag_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_res (div_res)
   );

   // page size, address shift and device size
   always_comb begin
      big = (density_ff == DENS_BIG_LO) || (density_ff == DENS_BIG_HI);
      if (binary_ff) begin
         psize      = big ? PSIZE_BIN_BIG : PSIZE_BIN_SMALL;
         page_shift = big ? SHIFT_BIN_BIG : SHIFT_BIN_SMALL;
      end else begin
         psize      = big ? PSIZE_EXT_BIG : PSIZE_EXT_SMALL;
         page_shift = big ? SHIFT_EXT_BIG : SHIFT_EXT_SMALL;
      end
      dsize_bin = (ADDR_W+1)'(1) << (5'(DEV_BASE_LOG2) + 5'(density_ff));
      dsize     = binary_ff ? dsize_bin : dsize_bin + (dsize_bin >> EXT_SCALE_SHIFT);
      req_end   = (ADDR_W+1)'(addr_ff) + (ADDR_W+1)'(len_ff);
      bad_req   = !ready_cfg_ff
               || (density_ff < DENS_MIN) || (density_ff > DENS_MAX)
               || (action_ff == ACT_BAD)
               || (32'(len_ff) > MAX_LENGTH)
               || (req_end > dsize)
               || ((action_ff != ACT_READ) && (len_ff == '0));
   end

   // segment of the current page
   always_comb begin
      room     = psize - off_ff;
      seg_last = remain_ff <= LEN_W'(room);
      seg      = seg_last ? remain_ff : LEN_W'(room);
      dev_addr = (ADDR_W'(page_ff) << page_shift) | ADDR_W'(off_ff);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      addr_in       = addr_ff;
      len_in        = len_ff;
      remain_in     = remain_ff;
      page_in       = page_ff;
      off_in        = off_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_op_in     = out_op_ff;
      out_dev_in    = out_dev_ff;
      out_cnt_in    = out_cnt_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      div_req       = '{start: 1'b0, dividend: addr_ff, divisor: psize};

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               action_in = action_type'(req_tdata[ACT_W-1:0]);
               addr_in   = req_tdata[ACT_W +: ADDR_W];
               len_in    = req_tdata[ACT_W+ADDR_W +: LEN_W];
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            if (bad_req) begin
               state_in = S_SEND;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_DIV_ADDR;
            end
         end
         S_DIV_ADDR: begin
            if (div_res.done) begin
               page_in   = div_res.quot[PAGE_W-1:0];
               off_in    = div_res.rem;
               remain_in = len_ff;
               if (action_ff == ACT_ERASE) begin
                  if (div_res.rem != '0) begin
                     state_in = S_SEND;
                  end else begin
                     div_req.start    = 1'b1;
                     div_req.dividend = ADDR_W'(len_ff);
                     state_in         = S_DIV_LEN;
                  end
               end else begin
                  state_in = S_STEP;
               end
            end
         end
         S_DIV_LEN: begin
            if (div_res.done) begin
               state_in = (div_res.rem != '0) ? S_SEND : S_STEP;
            end
         end
         S_STEP: begin
            out_dev_in    = dev_addr;
            out_status_in = 1'b0;
            if (action_ff == ACT_READ) begin
               out_op_in   = OP_READ;
               out_cnt_in  = len_ff;
               out_last_in = 1'b1;
            end else begin
               out_op_in   = (action_ff == ACT_ERASE) ? OP_ERASE : OP_PROGRAM;
               out_cnt_in  = (action_ff == ACT_ERASE) ? '0 : seg;
               out_last_in = seg_last;
            end
            remain_in    = remain_ff - seg;
            page_in      = page_ff + 1'b1;
            off_in       = '0;
            rsp_valid_in = 1'b1;
            state_in     = S_SEND;
         end
         S_SEND: begin
            if (rsp_valid_ff && rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = out_last_ff ? S_IDLE : S_STEP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // every way into S_SEND except from S_STEP is a rejection
      if ((state_in == S_SEND) && (state_ff != S_STEP) && (state_ff != S_SEND)) begin
         rsp_valid_in  = 1'b1;
         out_op_in     = OP_NONE;
         out_dev_in    = '0;
         out_cnt_in    = '0;
         out_status_in = 1'b1;
         out_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ready_cfg_ff <= 1'b0;
         density_ff   <= DENS_RESET;
         binary_ff    <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         // configuration writes
         if (csr_valid) begin
            unique case (csr_index_type'(csr_index))
               CSR_DEVICE_READY: ready_cfg_ff <= csr_data[0];
               CSR_DENSITY_CODE: density_ff   <= csr_data;
               CSR_BINARY_PAGES: binary_ff    <= csr_data[0];
               CSR_UNUSED:       ;
               default:          ;
            endcase
         end
      end
      action_ff     <= action_in;
      addr_ff       <= addr_in;
      len_ff        <= len_in;
      remain_ff     <= remain_in;
      page_ff       <= page_in;
      off_ff        <= off_in;
      out_op_ff     <= out_op_in;
      out_dev_ff    <= out_dev_in;
      out_cnt_ff    <= out_cnt_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-OP_W-ADDR_W-LEN_W)'(0), out_cnt_ff, out_dev_ff, out_op_ff};
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

FILE: sv/fpcag_checker.sv
`default_nettype none

`include "flash_page_command_address_gen_assert.svh"

// Port-level checks on the command generator.
module fpcag_checker
   import fpcag_pkg::*;
(
   input wire                   clock,
   input wire                   reset,
   input wire                   req_tvalid,
   input wire                   req_tready,
   input wire [RSP_DATA_W-1:0]  rsp_tdata,
   input wire                   rsp_tuser,
   input wire                   rsp_tlast,
   input wire                   rsp_tvalid,
   input wire                   rsp_tready
);

   // whole result item and its stall condition
   logic                  rsp_stall;
   logic [RSP_DATA_W+1:0] rsp_word;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tdata, rsp_tuser, rsp_tlast};

   // a stalled result holds
   `FPCAG_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

   // a new item only enters once all results of the last one are gone
   `FPCAG_ASSERT_IMP(a_no_overlap, clock, reset, req_tvalid && req_tready, !rsp_tvalid)

   // an error result is a single, all-zero, final result
   `FPCAG_ASSERT_IMP(a_err_shape, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast && (rsp_tdata == '0))

   // an accepted item keeps the input closed while it is worked on
   `FPCAG_ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

bind flash_page_command_address_gen fpcag_checker u_fpcag_checker (.*);

`default_nettype wire

FILE: sim/tb_flash_page_command_address_gen.sv
module tb_flash_page_command_address_gen;
   import fpcag_pkg::*;

   // one command word as it leaves the block
   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [ADDR_W-1:0] dev_addr;
      logic [LEN_W-1:0]  byte_count;
      logic              status;
      logic              last;
   } flash_cmd_type;

   logic                  clock;
   logic                  reset;
   // action[1:0], address[25:2], length[39:26]
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tvalid;
   logic                  req_tready;
   // opcode[7:0], device_address[31:8], byte_count[45:32], zeros above
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // status
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // register copies as the block should hold them
   logic              cfg_ready   = 1'b0;
   logic [DENS_W-1:0] cfg_density = DENS_RESET;
   logic              cfg_binary  = 1'b1;

   flash_cmd_type pending_cmds[$];
   int            mismatch_count = 0;
   bit            no_idle = 1'b0;

   flash_page_command_address_gen DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("FAIL flash_page_command_address_gen");
      $finish;
   end

   // page size, address shift and device bytes for the current registers
   function automatic bit page_geometry(output int unsigned psize, output int unsigned pbits,
                                        output int unsigned dsize);
      bit big;
      psize = 0;
      pbits = 0;
      dsize = 0;
      if (!cfg_ready || cfg_density < DENS_MIN || cfg_density > DENS_MAX) return 1'b0;
      big = (cfg_density == DENS_BIG_LO) || (cfg_density == DENS_BIG_HI);
      dsize = 32'h8000 << cfg_density;
      if (cfg_binary) begin
         psize = big ? PSIZE_BIN_BIG : PSIZE_BIN_SMALL;
      end else if (big) begin
         psize = PSIZE_EXT_BIG;
         pbits = SHIFT_EXT_BIG;
         dsize = (dsize / PSIZE_BIN_BIG) * PSIZE_EXT_BIG;
      end else begin
         psize = PSIZE_EXT_SMALL;
         pbits = SHIFT_EXT_SMALL;
         dsize = (dsize / PSIZE_BIN_SMALL) * PSIZE_EXT_SMALL;
      end
      return 1'b1;
   endfunction

   // linear byte address to page/offset form (unchanged for binary pages)
   function automatic logic [ADDR_W-1:0] device_form(int unsigned lin, int unsigned psize,
                                                     int unsigned pbits);
      if (pbits == 0) return ADDR_W'(lin);
      return ADDR_W'(((lin / psize) << pbits) | (lin % psize));
   endfunction

   function automatic flash_cmd_type make_cmd(logic [OP_W-1:0] op, logic [ADDR_W-1:0] dev,
                                              logic [LEN_W-1:0] cnt, logic st, logic lst);
      flash_cmd_type c;
      c.opcode     = op;
      c.dev_addr   = dev;
      c.byte_count = cnt;
      c.status     = st;
      c.last       = lst;
      return c;
   endfunction

   // queue up the command words one request should produce
   function automatic void predict_commands(action_type act, logic [ADDR_W-1:0] addr,
                                            logic [LEN_W-1:0] len);
      int unsigned psize, pbits, dsize, a, l, done, seg, off;
      a = addr;
      l = len;
      if (!page_geometry(psize, pbits, dsize) || act == ACT_BAD || l > MAX_LENGTH_DEF ||
          a + l > dsize) begin
         pending_cmds.push_back(make_cmd(OP_NONE, '0, '0, 1'b1, 1'b1));
         return;
      end
      if (act == ACT_READ) begin
         pending_cmds.push_back(make_cmd(OP_READ, device_form(a, psize, pbits), LEN_W'(l),
                                         1'b0, 1'b1));
         return;
      end
      // program and erase need data, erase needs whole pages
      if (l == 0 || (act == ACT_ERASE && (a % psize != 0 || l % psize != 0))) begin
         pending_cmds.push_back(make_cmd(OP_NONE, '0, '0, 1'b1, 1'b1));
         return;
      end
      done = 0;
      while (done < l) begin
         if (act == ACT_PROGRAM) begin
            off = (a + done) % psize;
            seg = l - done;
            if (seg > psize - off) seg = psize - off;
            pending_cmds.push_back(make_cmd(OP_PROGRAM, device_form(a + done, psize, pbits),
                                            LEN_W'(seg), 1'b0, (done + seg) >= l));
         end else begin
            seg = psize;
            pending_cmds.push_back(make_cmd(OP_ERASE, device_form(a + done, psize, pbits),
                                            '0, 1'b0, (done + seg) >= l));
         end
         done += seg;
      end
   endfunction

   // receiver backpressure
   always @(posedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(99) >= 32);
   end

   task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // compare every accepted command word with the oldest prediction
   always @(posedge clock) begin : check_commands
      flash_cmd_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cmds.size() == 0) begin
            $error("unexpected command word: tdata 0x%0h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_cmds.pop_front();
            check_field("opcode", 24'(want.opcode), 24'(rsp_tdata[7:0]));
            check_field("device_address", want.dev_addr, rsp_tdata[31:8]);
            check_field("byte_count", 24'(want.byte_count), 24'(rsp_tdata[45:32]));
            check_field("tdata_pad", 24'd0, 24'(rsp_tdata[47:46]));
            check_field("status", 24'(want.status), 24'(rsp_tuser));
            check_field("last", 24'(want.last), 24'(rsp_tlast));
         end
      end
   end

   // present one request, with an occasional random gap ahead of it
   task automatic send_request(action_type act, logic [ADDR_W-1:0] addr,
                               logic [LEN_W-1:0] len);
      if (!no_idle && $urandom_range(99) < 32) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 32);
      end
      req_tdata  <= {len, addr, act};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_commands(act, addr, len);
   endtask

   // stop sending and wait for every predicted word
   task automatic drain_commands();
      req_tvalid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DEVICE_READY: cfg_ready   = value[0];
         CSR_DENSITY_CODE: cfg_density = value;
         CSR_BINARY_PAGES: cfg_binary  = value[0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // 1-bit registers get junk in the unused data bits
   task automatic write_flag(csr_index_type idx, logic flag);
      write_csr(idx, {3'($urandom_range(7)), flag});
   endtask

   task automatic set_geometry(int density, logic binary);
      drain_commands();
      write_csr(CSR_DENSITY_CODE, DENS_W'(density));
      write_flag(CSR_BINARY_PAGES, binary);
   endtask

   // mostly well-formed requests for the current geometry, some pure noise
   task automatic send_random_request();
      int unsigned psize, pbits, dsize, npages, a, l;
      int r;
      action_type act;
      void'(page_geometry(psize, pbits, dsize));
      r = $urandom_range(99);
      if (r < 12 || dsize == 0) begin
         send_request(action_type'($urandom_range(3)), ADDR_W'($urandom), LEN_W'($urandom));
         return;
      end
      if (r < 45) act = ACT_READ;
      else if (r < 78) act = ACT_PROGRAM;
      else act = ACT_ERASE;
      if (act == ACT_ERASE) begin
         npages = ($urandom_range(9) == 0) ? MAX_LENGTH_DEF / psize : $urandom_range(1, 4);
         l = npages * psize;
         a = $urandom_range(dsize / psize - npages) * psize;
         if ($urandom_range(19) == 0) a += $urandom_range(1, psize - 1);
      end else begin
         case ($urandom_range(9))
            0: l = $urandom_range(psize, MAX_LENGTH_DEF);
            1: l = 0;
            2: l = MAX_LENGTH_DEF;
            default: l = $urandom_range(1, 2 * psize);
         endcase
         a = $urandom_range(dsize - l);
         // land just short of a page end so the split shows
         if ($urandom_range(2) == 0) begin
            a = (a / psize) * psize + psize - $urandom_range(1, 4);
            if (a + l > dsize) a = dsize - l;
         end
      end
      // just past the end of the device
      if ($urandom_range(24) == 0) a = dsize - l + $urandom_range(1, 16);
      send_request(act, ADDR_W'(a), LEN_W'(l));
   endtask

   // requests right after reset: device not ready
   task automatic test_not_ready();
      send_request(ACT_READ, '0, '0);
      send_request(ACT_PROGRAM, 24'h000100, 14'd16);
      drain_commands();
      write_csr(CSR_UNUSED, 4'($urandom_range(15)));
   endtask

   // bounds, lengths and every action on 256-byte pages, 256 KB device
   task automatic test_edge_requests();
      write_flag(CSR_DEVICE_READY, 1'b1);
      set_geometry(3, 1'b1);
      send_request(ACT_READ, '0, '0);
      send_request(ACT_READ, 24'h03FFFF, 14'd1);
      send_request(ACT_READ, 24'h040000, 14'd0);
      send_request(ACT_READ, 24'h040000, 14'd1);
      send_request(ACT_READ, 24'hFFFFFF, 14'd8192);
      send_request(ACT_READ, '0, 14'd8192);
      send_request(ACT_READ, '0, 14'd8193);
      send_request(ACT_READ, '0, 14'h3FFF);
      send_request(ACT_PROGRAM, '0, '0);
      send_request(ACT_PROGRAM, 24'h000001, 14'd8192);
      send_request(ACT_PROGRAM, 24'h0000FF, 14'd2);
      send_request(ACT_ERASE, '0, 14'd512);
      send_request(ACT_ERASE, 24'h000100, 14'd256);
      send_request(ACT_ERASE, 24'h000001, 14'd256);
      send_request(ACT_ERASE, '0, 14'd100);
      send_request(ACT_ERASE, '0, '0);
      send_request(ACT_BAD, '0, 14'd1);
      drain_commands();
   endtask

   // 264- and 528-byte pages, largest device
   task automatic test_extended_geometry();
      set_geometry(8, 1'b0);
      send_request(ACT_READ, 24'd8650751, 14'd1);
      send_request(ACT_ERASE, 24'd8650752 - 24'd264, 14'd264);
      send_request(ACT_PROGRAM, 24'd8650752 - 24'd300, 14'd300);
      set_geometry(6, 1'b0);
      send_request(ACT_PROGRAM, 24'd527, 14'd530);
      send_request(ACT_ERASE, 24'd528, 14'd1056);
      drain_commands();
   endtask

   // codes with no known page size
   task automatic test_bad_density();
      set_geometry(0, 1'b1);
      send_request(ACT_READ, '0, 14'd4);
      set_geometry(9, 1'b0);
      send_request(ACT_READ, '0, 14'd4);
      set_geometry(15, 1'b1);
      send_request(ACT_ERASE, '0, 14'd256);
      drain_commands();
   endtask

   task automatic test_random_traffic();
      int density_seq[8] = '{3, 8, 6, 7, 4, 5, 8, 6};
      bit binary_seq[8]  = '{1, 0, 0, 1, 0, 1, 1, 1};
      for (int i = 0; i < 8; i++) begin
         set_geometry(density_seq[i], binary_seq[i]);
         repeat (24) send_random_request();
      end
      drain_commands();
   endtask

   // no idling on either side
   task automatic test_back_to_back();
      no_idle = 1'b1;
      set_geometry(5, 1'b0);
      repeat (40) send_random_request();
      drain_commands();
      no_idle = 1'b0;
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_DEVICE_READY;
      csr_data   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_not_ready();
      test_edge_requests();
      test_extended_geometry();
      test_bad_density();
      test_random_traffic();
      test_back_to_back();

      // catch stray words after the last expected one
      drain_commands();
      repeat (80) @(posedge clock);
      if (mismatch_count == 0 && pending_cmds.size() == 0) begin
         $display("PASS flash_page_command_address_gen");
      end else begin
         $display("FAIL flash_page_command_address_gen");
      end
      $finish;
   end

endmodule
